// ===== rtl/core/sre_pkg.sv =====
// ----------------------------------------------------------------------------
// sre_pkg
// Types and the per-item encode step shared by the range encoder modules.
// ----------------------------------------------------------------------------
package sre_pkg;

    localparam int RES_MAX   = 4;   // result bytes one item can cause
    localparam int CNT_W     = 3;   // holds 0..RES_MAX
    localparam logic [1:0] RUN_SAT = 2'd3;
    localparam logic [1:0] RUN_HIT = 2'd2;

    // Encoder state kept between items
    typedef struct packed {
        logic [7:0] prev;
        logic [1:0] rise;
        logic [1:0] fall;
        logic       started;
        logic [7:0] pend0;
        logic [7:0] pend1;
        logic [1:0] pcnt;
    } sre_state_t;

    // Result bytes of one item, oldest in slot 0
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [RES_MAX-1:0]      lasts;
        logic [CNT_W-1:0]        n;
    } sre_emit_t;

    typedef struct packed {
        sre_state_t st;
        sre_emit_t  em;
    } sre_work_t;

    function automatic sre_work_t emit_byte(sre_work_t w, logic [7:0] b, logic fin);
        sre_work_t r;
        r = w;
        if (w.em.n < CNT_W'(RES_MAX))
        begin
            r.em.bytes[w.em.n[1:0]] = b;
            r.em.lasts[w.em.n[1:0]] = fin;
            r.em.n                  = w.em.n + CNT_W'(1);
        end
        return r;
    endfunction

    // Append one byte to the holdback pair; the oldest leaves when full
    function automatic sre_work_t produce(sre_work_t w, logic [7:0] b);
        sre_work_t r;
        r = w;
        if (w.st.pcnt >= 2'd2)
        begin
            r          = emit_byte(w, w.st.pend0, 1'b0);
            r.st.pend0 = w.st.pend1;
            r.st.pend1 = b;
            r.st.pcnt  = 2'd2;
        end
        else if (w.st.pcnt == 2'd0)
        begin
            r.st.pend0 = b;
            r.st.pcnt  = 2'd1;
        end
        else
        begin
            r.st.pend1 = b;
            r.st.pcnt  = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [1:0] sat_inc(logic [1:0] c);
        return (c == RUN_SAT) ? RUN_SAT : c + 2'd1;
    endfunction

    // One input item: next state and the bytes it releases
    function automatic sre_work_t encode_step(sre_state_t s, logic [7:0] v, logic fin,
                                              logic [7:0] mark_up, logic [7:0] mark_dn);
        sre_work_t  w;
        logic       hold;
        logic [1:0] old;
        logic [7:0] prev;
        w.st = s;
        w.em = '0;
        hold = 1'b0;
        prev = s.prev;
        old  = 2'd0;
        if (!s.started)
        begin
            w.st.rise    = 2'd0;
            w.st.fall    = 2'd0;
            w.st.pcnt    = 2'd0;
            w.st.prev    = v;
            w.st.started = 1'b1;
            w            = produce(w, v);
        end
        else
        begin
            // rising run, no wrap past 255
            if ({1'b0, v} == {1'b0, prev} + 9'd1)
            begin
                old       = w.st.rise;
                w.st.rise = sat_inc(old);
                if (old == RUN_HIT)
                begin
                    w.st.pcnt = 2'd0;
                    w         = produce(w, mark_up);
                end
                if (w.st.rise == RUN_SAT && !fin)
                begin
                    w.st.prev = v;
                    hold      = 1'b1;
                end
            end
            else
            begin
                if (w.st.rise == RUN_SAT)
                    w = produce(w, prev);
                w.st.rise = 2'd0;
            end
            // falling run, no wrap below 0
            if (!hold)
            begin
                if (prev != 8'd0 && v == prev - 8'd1)
                begin
                    old       = w.st.fall;
                    w.st.fall = sat_inc(old);
                    if (old == RUN_HIT)
                    begin
                        w.st.pcnt = 2'd0;
                        w         = produce(w, mark_dn);
                    end
                    if (w.st.fall == RUN_SAT && !fin)
                    begin
                        w.st.prev = v;
                        hold      = 1'b1;
                    end
                end
                else
                begin
                    if (w.st.fall == RUN_SAT)
                        w = produce(w, prev);
                    w.st.fall = 2'd0;
                end
            end
            if (!hold)
            begin
                w         = produce(w, v);
                w.st.prev = v;
            end
        end
        // end of stream: flush the holdback pair
        if (fin)
        begin
            if (w.st.pcnt != 2'd0)
                w = emit_byte(w, w.st.pend0, w.st.pcnt == 2'd1);
            if (w.st.pcnt == 2'd2)
                w = emit_byte(w, w.st.pend1, 1'b1);
            w.st.pcnt    = 2'd0;
            w.st.started = 1'b0;
            w.st.rise    = 2'd0;
            w.st.fall    = 2'd0;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/sre_core.sv =====
// ----------------------------------------------------------------------------
// sre_core
// Encoder state and the single-pass step logic for one registered item.
// ----------------------------------------------------------------------------
module sre_core #(
    parameter int MAX_VALUE = 120
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         value,
    input  logic               last_item,
    output sre_pkg::sre_emit_t emit
);
    import sre_pkg::*;

    localparam logic [7:0] MarkUp = 8'(MAX_VALUE + 1);
    localparam logic [7:0] MarkDn = 8'(MAX_VALUE + 2);

    sre_state_t state_reg;
    sre_work_t  step;

    always_comb
    begin
        step = encode_step(state_reg, value, last_item, MarkUp, MarkDn);
        emit = step.em;
    end

    // control state and holdback bytes; the bytes are read only below the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= step.st;
    end

endmodule

// ===== rtl/core/sre_obuf.sv =====
// ----------------------------------------------------------------------------
// sre_obuf
// Result register: holds the bytes of one item and shifts them out one a beat.
// ----------------------------------------------------------------------------
module sre_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sre_pkg::sre_emit_t emit,
    output logic               can_load,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] code_byte
    output logic               m_axis_tlast    // last_byte
);
    import sre_pkg::*;

    logic [RES_MAX-1:0][7:0] bytes_reg, bytes_next;
    logic [RES_MAX-1:0]      lasts_reg, lasts_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pop;

    assign pop      = (cnt_reg != '0) && m_axis_tready;
    assign can_load = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_axis_tready);

    always_comb
    begin
        bytes_next = bytes_reg;
        lasts_next = lasts_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            bytes_next = emit.bytes;
            lasts_next = emit.lasts;
            cnt_next   = emit.n;
        end
        else if (pop)
        begin
            // advance to the next byte
            bytes_next = bytes_reg >> 8;
            lasts_next = lasts_reg >> 1;
            cnt_next   = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        lasts_reg <= lasts_next;
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = bytes_reg[0];
    assign m_axis_tlast  = lasts_reg[0];

endmodule

// ===== rtl/core/sequential_range_encoder.sv =====
// ----------------------------------------------------------------------------
// sequential_range_encoder
// Byte stream encoder that folds rising or falling runs of four or more
// values into start value, run marker and end value.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata          | tlast      | accepted when
//  ---------+-----+----------------+------------+----------------------------
//  s_axis   | in  | [7:0] value    | last_item  | s_axis_tvalid & tready
//  m_axis   | out | [7:0] code_byte| last_byte  | m_axis_tvalid & tready
//
//  Flow: an item waits in the input register, then the step logic loads all
//  its result bytes (zero to four) into the result register in one pass. The
//  single-byte result port then sends them one a beat, and the next item can
//  load as the last byte leaves.
//  Reset: rst_n clears the run counters, stream flag, holdback count and both
//  valid flags at once; no clearing pass.
//  Stalls: the input register keeps taking items while the result register
//  drains its last byte; tready drops only while that register is busy.
//
module sequential_range_encoder #(
    parameter int MAX_VALUE = 120
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] value
    input  logic       s_axis_tlast,    // last_item
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] code_byte
    output logic       m_axis_tlast     // last_byte
);
    import sre_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] value_reg;
    logic       last_reg;

    logic       advance;
    logic       can_load;
    logic       in_accept;
    sre_emit_t  emit;

    // hand the registered item to the step logic once the result side frees up
    assign advance       = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // payload: capture on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            value_reg <= s_axis_tdata;
            last_reg  <= s_axis_tlast;
        end
    end

    // run detection, holdback pair and flush
    sre_core #(
        .MAX_VALUE (MAX_VALUE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .value     (value_reg),
        .last_item (last_reg),
        .emit      (emit)
    );

    // result register, one byte a beat
    sre_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .emit          (emit),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/sre_checker.sv =====
// ----------------------------------------------------------------------------
// sre_checker
// Port-level checks for the range encoder, bound to the top level.
// ----------------------------------------------------------------------------
module sre_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // input side only stalls behind buffered results
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // a stalled input beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // nothing to send right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind sequential_range_encoder sre_checker u_sre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
